@@ rtl/core/gbsc_pkg.sv @@
package gbsc_pkg;

  localparam int PIN_COUNT = 32;
  localparam int WORD_W    = 32;

  localparam logic [WORD_W-1:0] PIN_MASK =
    WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

  localparam int OPC_W = 2;
  localparam int OFS_W = 5;

  // Access kinds; the third code (OP_IDLE) acts as an idle tick.
  localparam logic [OPC_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPC_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPC_W-1:0] OP_IDLE  = 2'd2;

  // Register byte offsets.
  localparam logic [OFS_W-1:0] OFS_OE       = 5'h00;
  localparam logic [OFS_W-1:0] OFS_OE_CLR   = 5'h04;
  localparam logic [OFS_W-1:0] OFS_DAT      = 5'h08;
  localparam logic [OFS_W-1:0] OFS_IN       = 5'h0C;
  localparam logic [OFS_W-1:0] OFS_IRQ_EN   = 5'h10;
  localparam logic [OFS_W-1:0] OFS_IRQ_STAT = 5'h14;
  localparam logic [OFS_W-1:0] OFS_NPOL     = 5'h18;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [OFS_W-1:0]  offset;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] drive_enable;
    logic [WORD_W-1:0] drive_value;
    logic              irq_out;
  } res_t;

endpackage

@@ rtl/core/gbsc_in_stage.sv @@
module gbsc_in_stage
  import gbsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [OPC_W-1:0]     s_tuser,
  input  logic                 advance,
  output logic                 req_valid,
  output req_t                 req
);

  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  // Hold payload while the stage is stalled.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.opcode <= s_tuser;
      req.offset <= s_tdata[OFS_W-1:0];
      req.write_data <= s_tdata[OFS_W +: WORD_W];
      req.pin_levels <= s_tdata[OFS_W+WORD_W +: WORD_W];
    end
  end

endmodule

@@ rtl/core/gbsc_regfile.sv @@
module gbsc_regfile
  import gbsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output res_t res
);

  logic [WORD_W-1:0] enable_bits,     enable_bits_next;
  logic [WORD_W-1:0] data_bits,       data_bits_next;
  logic [WORD_W-1:0] irq_mask_bits,   irq_mask_bits_next;
  logic [WORD_W-1:0] low_active_bits, low_active_bits_next;
  logic [WORD_W-1:0] sampled_pins_next;
  logic [WORD_W-1:0] wmask;
  logic [WORD_W-1:0] status_next;
  logic [WORD_W-1:0] rdata;

  assign wmask             = req.write_data & PIN_MASK;
  assign sampled_pins_next = req.pin_levels & PIN_MASK;
  assign status_next       = (sampled_pins_next ^ low_active_bits_next) & PIN_MASK;

  always_comb begin
    enable_bits_next     = enable_bits;
    data_bits_next       = data_bits;
    irq_mask_bits_next   = irq_mask_bits;
    low_active_bits_next = low_active_bits;
    if (req.opcode == OP_WRITE) begin
      case (req.offset)
        OFS_OE:     enable_bits_next     = enable_bits | wmask;
        OFS_OE_CLR: enable_bits_next     = enable_bits & ~wmask;
        OFS_DAT:    data_bits_next       = data_bits | wmask;
        OFS_IN:     data_bits_next       = data_bits & ~wmask;
        OFS_IRQ_EN: irq_mask_bits_next   = wmask;
        OFS_NPOL:   low_active_bits_next = wmask;
        default:    ;
      endcase
    end
  end

  // A read leaves the state alone, so post-access values serve the read too.
  always_comb begin
    rdata = '0;
    if (req.opcode == OP_READ) begin
      case (req.offset)
        OFS_OE:       rdata = enable_bits;
        OFS_DAT:      rdata = data_bits;
        OFS_IN:       rdata = sampled_pins_next;
        OFS_IRQ_EN:   rdata = irq_mask_bits;
        OFS_IRQ_STAT: rdata = status_next;
        default:      rdata = '0;
      endcase
    end
  end

  assign res.read_data    = rdata;
  assign res.drive_enable = enable_bits_next;
  assign res.drive_value  = data_bits_next;
  assign res.irq_out      = |(status_next & irq_mask_bits_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bits     <= '0;
      data_bits       <= '0;
      irq_mask_bits   <= '0;
      low_active_bits <= '0;
    end else if (fire) begin
      enable_bits     <= enable_bits_next;
      data_bits       <= data_bits_next;
      irq_mask_bits   <= irq_mask_bits_next;
      low_active_bits <= low_active_bits_next;
    end
  end

endmodule

@@ rtl/core/gbsc_out_stage.sv @@
module gbsc_out_stage
  import gbsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  res_t                  res,
  output logic                  advance,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  res_t held;

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {
    {(OUT_DATA_W - 3*WORD_W - 1){1'b0}},
    held.irq_out,
    held.drive_value,
    held.drive_enable,
    held.read_data
  };

endmodule

@@ rtl/core/gpio_bank_set_clear_level_irq_core.sv @@
// Each request is held in the input register, its result in the result register.
// Throughput, while m_tready stays high: one request per cycle; each request
// passes once through the bitwise register update between the two registers.
// Reset (rst, synchronous, active high) clears both stage valids and all
// bank registers: pins are inputs, interrupts disabled, polarity active high.
module gpio_bank_set_clear_level_irq_core
  import gbsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: offset[4:0], write_data[36:5], pin_levels[68:37], zero pad [71:69]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [OPC_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: read_data[31:0], drive_enable[63:32], drive_value[95:64],
  //          irq_out[96], zero pad [103:97]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic req_valid;
  logic advance;
  logic fire;
  req_t req;
  res_t res;

  // Input register: takes a new request whenever the held one moves on.
  gbsc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  // Commit the bank update only in the cycle the request reaches the result
  // register, so a stalled request never applies twice.
  assign fire = req_valid && advance;

  // Bank registers: pin sampling, set/clear updates, read mux, level IRQ.
  gbsc_regfile u_regs (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .res  (res)
  );

  // Result register: parts the master side from the request side.
  gbsc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (req_valid),
    .res       (res),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ rtl/core/gbsc_checker.sv @@
module gbsc_checker
  import gbsc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset drops any pending result.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A draining master side never stalls the request side.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("request stalled while results drain");

  // An empty result register always leaves room for a request.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled with empty output");

endmodule

bind gpio_bank_set_clear_level_irq_core gbsc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
